[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the health monitor RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cbhm_pkg.sv]
// ---------------------------------------------------------------------------
// Circuit breaker health monitor package
// Action, mode and register codes, fixed field widths and shared types.
// ---------------------------------------------------------------------------
package cbhm_pkg;

    // Fixed field widths
    localparam int RUN_W      = 16;
    localparam int MINC_W     = 7;
    localparam int RATE_W     = 9;
    localparam int LIMIT_W    = 32;
    localparam int ACT_W      = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_SUCCESS = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FAILURE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ROUTE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DISABLE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ENABLE  = 3'd4;

    // Health modes
    localparam logic [MODE_W-1:0] MODE_HEALTHY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEGRADED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OPEN     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DISABLED = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUCC_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_DELAY = 3'd5;

    // Result of the shared age compare unit
    typedef struct packed {
        logic older;    // age strictly above the limit
        logic reached;  // age at or above the limit
    } age_t;

endpackage

[rtl/circuit_breaker_health_monitor.sv]
// ---------------------------------------------------------------------------
// Circuit breaker health monitor
// Tracks primary path health from outcome reports over a rolling window.
// ---------------------------------------------------------------------------
// Busy after an accepted beat: exec, finish (route, disable, enable, unused);
// push, settle, prune, finish (success); push, settle, prune, rate, trip,
// finish (failure). Prune removes one entry per cycle on the shared age unit.
// The result strobe comes in the same cycle that busy falls; a new start may
// be taken in that same cycle. The receiver cannot stall results.
// Asynchronous active-low reset; ring contents need no clearing pass.
module circuit_breaker_health_monitor #(
    parameter int WINDOW_DEPTH = 64,
    parameter int TIME_BITS    = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Item channel
    input  logic                                start,
    output logic                                busy,
    input  logic [cbhm_pkg::ACT_W-1:0]          action,
    input  logic [TIME_BITS-1:0]                now_ms,
    // Result channel
    output logic                                done,
    output logic [cbhm_pkg::MODE_W-1:0]         health_state,
    output logic                                use_primary,
    output logic                                probing,
    output logic                                tripped_now,
    output logic [cbhm_pkg::RUN_W-1:0]          failure_streak,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]   window_total,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]   window_failures,
    output logic [cbhm_pkg::RUN_W-1:0]          trip_count,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbhm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [cbhm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [cbhm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import cbhm_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH+1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int MIN_W  = (CNT_W > MINC_W) ? CNT_W : MINC_W;
    localparam int PROD_W = CNT_W + RATE_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(WINDOW_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SETTLE,
        S_PRUNE,
        S_RATE,
        S_TRIP,
        S_EXEC,
        S_FINISH
    } state_t;

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic [RUN_W-1:0]     fail_limit_reg;
    logic [RUN_W-1:0]     succ_limit_reg;
    logic [LIMIT_W-1:0]   window_len_reg;
    logic [MINC_W-1:0]    min_count_reg;
    logic [RATE_W-1:0]    rate_limit_reg;
    logic [LIMIT_W-1:0]   probe_delay_reg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Write a register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_limit_reg  <= RUN_W'(5);
            succ_limit_reg  <= RUN_W'(3);
            window_len_reg  <= LIMIT_W'(60000);
            min_count_reg   <= MINC_W'(10);
            rate_limit_reg  <= RATE_W'(128);
            probe_delay_reg <= LIMIT_W'(30000);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                CFG_FAIL_LIMIT:  fail_limit_reg  <= pwdata[RUN_W-1:0];
                CFG_SUCC_LIMIT:  succ_limit_reg  <= pwdata[RUN_W-1:0];
                CFG_WINDOW_LEN:  window_len_reg  <= pwdata[LIMIT_W-1:0];
                CFG_MIN_COUNT:   min_count_reg   <= pwdata[MINC_W-1:0];
                CFG_RATE_LIMIT:  rate_limit_reg  <= pwdata[RATE_W-1:0];
                CFG_PROBE_DELAY: probe_delay_reg <= pwdata[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (cfg_idx)
            CFG_FAIL_LIMIT:  prdata = CFG_DATA_W'(fail_limit_reg);
            CFG_SUCC_LIMIT:  prdata = CFG_DATA_W'(succ_limit_reg);
            CFG_WINDOW_LEN:  prdata = CFG_DATA_W'(window_len_reg);
            CFG_MIN_COUNT:   prdata = CFG_DATA_W'(min_count_reg);
            CFG_RATE_LIMIT:  prdata = CFG_DATA_W'(rate_limit_reg);
            CFG_PROBE_DELAY: prdata = CFG_DATA_W'(probe_delay_reg);
            default:         prdata = '0;
        endcase
    end

    // -----------------------------------------------------------------------
    // Sequencer state
    // -----------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [ACT_W-1:0]     action_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [RUN_W-1:0]     fail_run_reg, fail_run_next;
    logic [RUN_W-1:0]     succ_run_reg, succ_run_next;
    logic                 probe_reg, probe_next;
    logic [TIME_BITS-1:0] open_time_reg, open_time_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     fails_reg, fails_next;
    logic [RUN_W-1:0]     trips_reg, trips_next;
    logic                 tripped_reg, tripped_next;
    logic [PROD_W-1:0]    prod_reg;
    logic                 rate_gate_reg;

    logic                 done_reg;
    logic [MODE_W-1:0]    health_state_reg;
    logic                 use_primary_reg;
    logic                 probing_reg;
    logic                 tripped_now_reg;
    logic [RUN_W-1:0]     failure_streak_reg;
    logic [CNT_W-1:0]     window_total_reg;
    logic [CNT_W-1:0]     window_failures_reg;
    logic [RUN_W-1:0]     trip_count_reg;

    // Ring and age unit hookup
    logic                 ring_wr;
    logic [IDX_W-1:0]     ring_slot;
    logic                 rd_ok;
    logic [TIME_BITS-1:0] rd_time;
    logic [TIME_BITS-1:0] age_ref;
    logic [LIMIT_W-1:0]   age_limit;
    age_t                 age;

    // Scratch values
    logic [SUM_W-1:0]     slot_sum;
    logic [IDX_W-1:0]     head_inc;
    logic                 full;
    logic [CNT_W-1:0]     fails_pop;
    logic [RUN_W-1:0]     succ_inc;
    logic                 trip;
    logic                 rate_hit;
    logic [PROD_W-1:0]    fails_scaled;
    logic                 use_now;

    cbhm_ring #(
        .DEPTH     (WINDOW_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr),
        .wr_addr (ring_slot),
        .wr_ok   (action_reg == ACT_SUCCESS),
        .wr_time (now_reg),
        .rd_addr (head_next),
        .rd_ok   (rd_ok),
        .rd_time (rd_time)
    );

    // Prune compares entry age with the window; otherwise open age with delay
    assign age_ref   = (state_reg == S_PRUNE) ? rd_time : open_time_reg;
    assign age_limit = (state_reg == S_PRUNE) ? window_len_reg : probe_delay_reg;

    cbhm_age_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_age (
        .now_time (now_reg),
        .ref_time (age_ref),
        .limit    (age_limit),
        .result   (age)
    );

    // Ring pointer arithmetic
    always_comb
    begin
        slot_sum     = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (slot_sum >= DEPTH_SUM)
        begin
            slot_sum = slot_sum - DEPTH_SUM;
        end
        ring_slot    = slot_sum[IDX_W-1:0];
        head_inc     = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
        full         = (count_reg == DEPTH_CNT);
        fails_pop    = (!rd_ok && (fails_reg != '0)) ? fails_reg - CNT_W'(1) : fails_reg;
        succ_inc     = (succ_run_reg != RUN_MAX) ? succ_run_reg + RUN_W'(1) : succ_run_reg;
        fails_scaled = PROD_W'({fails_reg, 8'd0});
        rate_hit     = rate_gate_reg && (fails_scaled >= prod_reg);
        trip         = (fail_run_reg >= fail_limit_reg) || rate_hit;
        ring_wr      = (state_reg == S_PUSH);
    end

    // Use decision on the final state
    always_comb
    begin
        unique case (mode_reg)
            MODE_HEALTHY,
            MODE_DEGRADED: use_now = 1'b1;
            MODE_OPEN:     use_now = probe_reg || age.reached;
            default:       use_now = 1'b0;
        endcase
    end

    // Next-state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        fail_run_next  = fail_run_reg;
        succ_run_next  = succ_run_reg;
        probe_next     = probe_reg;
        open_time_next = open_time_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        fails_next     = fails_reg;
        trips_next     = trips_reg;
        tripped_next   = tripped_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    tripped_next = 1'b0;
                    if ((action == ACT_SUCCESS) || (action == ACT_FAILURE))
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            S_PUSH:
            begin
                // Drop the oldest entry when full, then append
                if (full)
                begin
                    head_next  = head_inc;
                    fails_next = fails_pop;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (action_reg == ACT_SUCCESS)
                begin
                    fail_run_next = '0;
                    succ_run_next = succ_inc;
                    if (probe_reg)
                    begin
                        if (succ_inc >= succ_limit_reg)
                        begin
                            probe_next = 1'b0;
                            mode_next  = MODE_HEALTHY;
                        end
                    end
                    else if ((mode_reg == MODE_DEGRADED) && (succ_inc >= succ_limit_reg))
                    begin
                        mode_next = MODE_HEALTHY;
                    end
                end
                else
                begin
                    fails_next    = (full ? fails_pop : fails_reg) + CNT_W'(1);
                    fail_run_next = (fail_run_reg != RUN_MAX) ?
                                    fail_run_reg + RUN_W'(1) : fail_run_reg;
                    succ_run_next = '0;
                end
                state_next = S_SETTLE;
            end

            S_SETTLE:
            begin
                state_next = S_PRUNE;
            end

            S_PRUNE:
            begin
                // Remove one aged entry per cycle from the head
                if ((count_reg != '0) && age.older)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                    fails_next = fails_pop;
                end
                else if (action_reg == ACT_FAILURE)
                begin
                    state_next = S_RATE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_RATE:
            begin
                state_next = S_TRIP;
            end

            S_TRIP:
            begin
                if (trip)
                begin
                    if (probe_reg || (mode_reg == MODE_DEGRADED))
                    begin
                        probe_next     = 1'b0;
                        open_time_next = now_reg;
                        trips_next     = (trips_reg != RUN_MAX) ?
                                         trips_reg + RUN_W'(1) : trips_reg;
                        mode_next      = MODE_OPEN;
                        tripped_next   = 1'b1;
                    end
                    else if (mode_reg == MODE_HEALTHY)
                    begin
                        mode_next = MODE_DEGRADED;
                    end
                end
                state_next = S_FINISH;
            end

            S_EXEC:
            begin
                case (action_reg)
                    ACT_ROUTE:
                    begin
                        if ((mode_reg == MODE_OPEN) && !probe_reg && age.reached)
                        begin
                            probe_next    = 1'b1;
                            succ_run_next = '0;
                        end
                    end
                    ACT_DISABLE:
                    begin
                        mode_next = MODE_DISABLED;
                    end
                    ACT_ENABLE:
                    begin
                        if (mode_reg != MODE_HEALTHY)
                        begin
                            fail_run_next  = '0;
                            succ_run_next  = '0;
                            probe_next     = 1'b0;
                            open_time_next = '0;
                            head_next      = '0;
                            count_next     = '0;
                            fails_next     = '0;
                            mode_next      = MODE_HEALTHY;
                        end
                    end
                    default: ;
                endcase
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            action_reg          <= ACT_SUCCESS;
            now_reg             <= '0;
            mode_reg            <= MODE_HEALTHY;
            fail_run_reg        <= '0;
            succ_run_reg        <= '0;
            probe_reg           <= 1'b0;
            open_time_reg       <= '0;
            head_reg            <= '0;
            count_reg           <= '0;
            fails_reg           <= '0;
            trips_reg           <= '0;
            tripped_reg         <= 1'b0;
            prod_reg            <= '0;
            rate_gate_reg       <= 1'b0;
            done_reg            <= 1'b0;
            health_state_reg    <= MODE_HEALTHY;
            use_primary_reg     <= 1'b0;
            probing_reg         <= 1'b0;
            tripped_now_reg     <= 1'b0;
            failure_streak_reg  <= '0;
            window_total_reg    <= '0;
            window_failures_reg <= '0;
            trip_count_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            fail_run_reg  <= fail_run_next;
            succ_run_reg  <= succ_run_next;
            probe_reg     <= probe_next;
            open_time_reg <= open_time_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            fails_reg     <= fails_next;
            trips_reg     <= trips_next;
            tripped_reg   <= tripped_next;
            done_reg      <= (state_reg == S_FINISH);

            // Latch the accepted beat
            if ((state_reg == S_IDLE) && start)
            begin
                action_reg <= action;
                now_reg    <= now_ms;
            end

            // Register the rate product and its gate
            if (state_reg == S_RATE)
            begin
                prod_reg      <= PROD_W'(rate_limit_reg) * PROD_W'(count_reg);
                rate_gate_reg <= (count_reg != '0) &&
                                 (MIN_W'(count_reg) >= MIN_W'(min_count_reg));
            end

            // Capture the result beat
            if (state_reg == S_FINISH)
            begin
                health_state_reg    <= mode_reg;
                use_primary_reg     <= use_now;
                probing_reg         <= probe_reg;
                tripped_now_reg     <= tripped_reg;
                failure_streak_reg  <= fail_run_reg;
                window_total_reg    <= count_reg;
                window_failures_reg <= fails_reg;
                trip_count_reg      <= trips_reg;
            end
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign health_state    = health_state_reg;
    assign use_primary     = use_primary_reg;
    assign probing         = probing_reg;
    assign tripped_now     = tripped_now_reg;
    assign failure_streak  = failure_streak_reg;
    assign window_total    = window_total_reg;
    assign window_failures = window_failures_reg;
    assign trip_count      = trip_count_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_CNT,
        "ring count exceeds depth")
    `ASSERT_SAME(a_fails_bound, clk, rst_n, 1'b1, fails_reg <= count_reg,
        "window failures exceed window total")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, state_reg != S_IDLE,
        "accepted beat did not start the sequencer")
    `ASSERT_SAME(a_done_src, clk, rst_n, done_reg, $past(state_reg == S_FINISH),
        "result strobe without a finish step")
    `ASSERT_SAME(a_trip_open, clk, rst_n, done_reg && tripped_now_reg,
        health_state_reg == MODE_OPEN,
        "trip reported while breaker not open")

endmodule

[rtl/cbhm_age_unit.sv]
// ---------------------------------------------------------------------------
// Shared age compare unit
// Wrapping time subtract followed by a compare against a 32-bit limit.
// ---------------------------------------------------------------------------
module cbhm_age_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic [TIME_BITS-1:0]        now_time,
    input  logic [TIME_BITS-1:0]        ref_time,
    input  logic [cbhm_pkg::LIMIT_W-1:0] limit,
    output cbhm_pkg::age_t              result
);
    import cbhm_pkg::*;

    localparam int CMP_W = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

    logic [TIME_BITS-1:0] age;
    logic [CMP_W-1:0]     age_ext;
    logic [CMP_W-1:0]     limit_ext;

    // Subtract modulo the time width, then compare at a common width
    always_comb
    begin
        age            = now_time - ref_time;
        age_ext        = CMP_W'(age);
        limit_ext      = CMP_W'(limit);
        result.older   = (age_ext > limit_ext);
        result.reached = (age_ext >= limit_ext);
    end

endmodule

[rtl/cbhm_ring.sv]
// ---------------------------------------------------------------------------
// Outcome ring memory
// One write port and one registered read port over timestamped outcomes.
// ---------------------------------------------------------------------------
module cbhm_ring #(
    parameter int DEPTH     = 64,
    parameter int TIME_BITS = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic                     wr_ok,
    input  logic [TIME_BITS-1:0]     wr_time,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic                     rd_ok,
    output logic [TIME_BITS-1:0]     rd_time
);

    logic [TIME_BITS:0] mem [DEPTH];
    logic [TIME_BITS:0] rd_q;

    // Store one outcome
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_ok, wr_time};
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        rd_q <= mem[rd_addr];
    end

    assign rd_ok   = rd_q[TIME_BITS];
    assign rd_time = rd_q[TIME_BITS-1:0];

endmodule
